// ----- hdl/hmmtec_pkg.sv -----
`default_nettype none

package hmmtec_pkg;

   // Field and table geometry.
   localparam int STATE_BITS      = 6;
   localparam int SYMBOL_BITS     = 10;
   localparam int COUNT_BITS      = 32;
   localparam int MAX_STATES      = 64;
   localparam int MAX_SYMBOLS     = 1024;
   localparam int EMIT_DEPTH      = MAX_STATES * MAX_SYMBOLS;
   localparam int TRANS_DEPTH     = MAX_STATES * MAX_STATES;
   localparam int EMIT_ADDR_BITS  = STATE_BITS + SYMBOL_BITS;
   localparam int TRANS_ADDR_BITS = 2 * STATE_BITS;

   // Configuration registers.
   localparam int STATES_REG_BITS  = 7;
   localparam int SYMBOLS_REG_BITS = 11;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int CSR_DATA_BITS    = 11;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_STATES  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_SYMBOLS = 1'b1;
   localparam logic [STATES_REG_BITS-1:0]  ACTIVE_STATES_RESET  = 7'd64;
   localparam logic [SYMBOLS_REG_BITS-1:0] ACTIVE_SYMBOLS_RESET = 11'd1024;

   // Stream payloads.
   localparam int REQ_TDATA_BITS = 24;
   localparam int RSP_TDATA_BITS = 5 * COUNT_BITS;
   localparam int RSP_TUSER_BITS = 2;

   // Request kinds.
   localparam logic KIND_COUNT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef logic [COUNT_BITS-1:0] count_type;

   // Increment that holds at the maximum value.
   function automatic count_type sat_inc(input count_type value);
      count_type result;
      if (value == COUNT_MAX) begin
         result = value;
      end else begin
         result = value + count_type'(1);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/hmm_transition_emission_counter.sv -----
// Channel   Direction  Accepted when             Payload
// req_*     in         req_tvalid & req_tready   tdata: word, label, from_label,
//                                                sentence_start; tuser: kind
// rsp_*     out        rsp_tvalid & rsp_tready   tdata: five counters;
//                                                tuser: range_error, saturated
// csr_*     in         csr_we                    csr_index, csr_wdata
//
// For each request, the accept edge issues the reads of the four counter
// memories; the write-back edge then writes the updated counters back and
// loads the response register. A request is taken while an earlier response
// waits. After reset a clearing pass zeroes the memories, sweeping all 65536
// addresses, during which no request is accepted; configuration writes are
// taken at any time. Write-back stalls while a full response is not taken.
`default_nettype none

module hmm_transition_emission_counter (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [9:0] word, [15:10] label, [21:16] from_label, [22] sentence_start
   input  logic [hmmtec_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // [0] kind
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [31:0] emission_count, [63:32] transition_count, [95:64] category_count,
   // [127:96] first_count, [159:128] sentence_count
   output logic [hmmtec_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // [0] range_error, [1] saturated
   output logic [hmmtec_pkg::RSP_TUSER_BITS-1:0] rsp_tuser,
   input  logic csr_we,
   input  logic [hmmtec_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hmmtec_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import hmmtec_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_WRITE = 1'b1;

   logic state_ff, state_in;
   logic clearing_ff;
   logic [EMIT_ADDR_BITS-1:0] clr_ff;

   logic [STATES_REG_BITS-1:0]  active_states_ff;
   logic [SYMBOLS_REG_BITS-1:0] active_symbols_ff;

   logic                   kind_ff;
   logic [SYMBOL_BITS-1:0] word_ff;
   logic [STATE_BITS-1:0]  label_ff;
   logic [STATE_BITS-1:0]  from_ff;
   logic                   start_ff;

   logic [STATE_BITS-1:0] prior_label_ff;
   logic                  sentence_open_ff;
   count_type             sentences_seen_ff;

   logic                      rsp_valid_ff;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff;
   logic [RSP_TUSER_BITS-1:0] rsp_user_ff;

   count_type em_mem [EMIT_DEPTH];
   count_type tr_mem [TRANS_DEPTH];
   count_type cat_mem [MAX_STATES];
   count_type fi_mem [MAX_STATES];
   count_type em_rd_ff, tr_rd_ff, cat_rd_ff, fi_rd_ff;

   logic                   accept;
   logic                   out_free;
   logic                   do_commit;
   logic                   upd;
   logic                   bad;
   logic                   held;
   logic [SYMBOL_BITS-1:0] req_word;
   logic [STATE_BITS-1:0]  req_label;
   logic [STATE_BITS-1:0]  req_from;
   logic [STATE_BITS-1:0]  tr_row;
   logic [EMIT_ADDR_BITS-1:0]  em_waddr;
   logic [TRANS_ADDR_BITS-1:0] tr_waddr;
   logic [STATE_BITS-1:0]      lb_waddr;
   count_type em_new, tr_new, cat_new, fi_new, sen_new;
   count_type em_out, tr_out, cat_out, fi_out, sen_out;

   assign req_word  = req_tdata[9:0];
   assign req_label = req_tdata[15:10];
   assign req_from  = req_tdata[21:16];

   assign req_tready = (state_ff == ST_IDLE) && !clearing_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign do_commit  = (state_ff == ST_WRITE) && out_free;

   // A transition read uses the given source; a count uses the previous label.
   assign tr_row = (req_tuser == KIND_READ) ? req_from : prior_label_ff;

   always_comb begin
      bad = ({1'b0, label_ff} >= active_states_ff) ||
            ({1'b0, word_ff} >= active_symbols_ff);
      if (kind_ff == KIND_READ) begin
         if ({1'b0, from_ff} >= active_states_ff) begin
            bad = 1'b1;
         end
      end else if (!start_ff &&
                   (!sentence_open_ff || ({1'b0, prior_label_ff} >= active_states_ff))) begin
         bad = 1'b1;
      end
   end

   assign upd = do_commit && (kind_ff == KIND_COUNT) && !bad;

   assign em_new  = sat_inc(em_rd_ff);
   assign tr_new  = sat_inc(tr_rd_ff);
   assign cat_new = sat_inc(cat_rd_ff);
   assign fi_new  = sat_inc(fi_rd_ff);
   assign sen_new = sat_inc(sentences_seen_ff);

   always_comb begin
      em_out  = '0;
      tr_out  = '0;
      cat_out = '0;
      fi_out  = '0;
      sen_out = '0;
      held    = 1'b0;
      if (!bad) begin
         if (kind_ff == KIND_READ) begin
            em_out  = em_rd_ff;
            tr_out  = tr_rd_ff;
            cat_out = cat_rd_ff;
            fi_out  = fi_rd_ff;
            sen_out = sentences_seen_ff;
         end else begin
            em_out  = em_new;
            cat_out = cat_new;
            held    = (em_rd_ff == COUNT_MAX) || (cat_rd_ff == COUNT_MAX);
            if (start_ff) begin
               fi_out  = fi_new;
               sen_out = sen_new;
               held    = held || (fi_rd_ff == COUNT_MAX) ||
                         (sentences_seen_ff == COUNT_MAX);
            end else begin
               tr_out  = tr_new;
               fi_out  = fi_rd_ff;
               sen_out = sentences_seen_ff;
               held    = held || (tr_rd_ff == COUNT_MAX);
            end
         end
      end
   end

   // During the clearing pass the sweep counter drives every write port.
   assign em_waddr = clearing_ff ? clr_ff : {label_ff, word_ff};
   assign tr_waddr = clearing_ff ? clr_ff[TRANS_ADDR_BITS-1:0] : {prior_label_ff, label_ff};
   assign lb_waddr = clearing_ff ? clr_ff[STATE_BITS-1:0] : label_ff;

   always_ff @(posedge clock) begin
      if (clearing_ff || upd) begin
         em_mem[em_waddr] <= clearing_ff ? '0 : em_new;
      end
      if (accept) begin
         em_rd_ff <= em_mem[{req_label, req_word}];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff || (upd && !start_ff)) begin
         tr_mem[tr_waddr] <= clearing_ff ? '0 : tr_new;
      end
      if (accept) begin
         tr_rd_ff <= tr_mem[{tr_row, req_label}];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff || upd) begin
         cat_mem[lb_waddr] <= clearing_ff ? '0 : cat_new;
      end
      if (accept) begin
         cat_rd_ff <= cat_mem[req_label];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff || (upd && start_ff)) begin
         fi_mem[lb_waddr] <= clearing_ff ? '0 : fi_new;
      end
      if (accept) begin
         fi_rd_ff <= fi_mem[req_label];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (do_commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         clearing_ff       <= 1'b1;
         clr_ff            <= '0;
         active_states_ff  <= ACTIVE_STATES_RESET;
         active_symbols_ff <= ACTIVE_SYMBOLS_RESET;
         prior_label_ff    <= '0;
         sentence_open_ff  <= 1'b0;
         sentences_seen_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == '1) begin
               clearing_ff <= 1'b0;
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_ACTIVE_STATES:  active_states_ff  <= csr_wdata[STATES_REG_BITS-1:0];
               CSR_ACTIVE_SYMBOLS: active_symbols_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (upd) begin
            prior_label_ff <= label_ff;
            if (start_ff) begin
               sentence_open_ff  <= 1'b1;
               sentences_seen_ff <= sen_new;
            end
         end
         if (do_commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_tuser;
         word_ff  <= req_word;
         label_ff <= req_label;
         from_ff  <= req_from;
         start_ff <= req_tdata[22];
      end
      if (do_commit) begin
         rsp_data_ff <= {sen_out, fi_out, cat_out, tr_out, em_out};
         rsp_user_ff <= {held, bad};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef NO_ASSERTIONS
   // An accepted request always moves on to its write-back cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_WRITE))
      else $error("accepted request did not reach write-back");

   // A write-back cycle always presents a response on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      do_commit |=> rsp_tvalid)
      else $error("write-back did not load the response register");

   // A blocked response holds the request in write-back.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WRITE) && rsp_tvalid && !rsp_tready) |=> (state_ff == ST_WRITE))
      else $error("write-back left while the response register was full");

   // No request is taken or updated while the memories are being cleared.
   assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> (!accept && !upd))
      else $error("request handled during clearing pass");

   // The sentence counter only moves up between resets.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (sentences_seen_ff >= $past(sentences_seen_ff)))
      else $error("sentence counter decreased");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_hmm_transition_emission_counter.sv -----
`timescale 1ns / 1ps

module tb_hmm_transition_emission_counter;
   import hmmtec_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 113;

   typedef struct {
      logic                   kind;
      logic [SYMBOL_BITS-1:0] word;
      logic [STATE_BITS-1:0]  label;
      logic [STATE_BITS-1:0]  from_label;
      logic                   sentence_start;
   } count_request_type;

   typedef struct {
      logic [31:0] emission;
      logic [31:0] transition;
      logic [31:0] category;
      logic [31:0] first_label;
      logic [31:0] sentences;
      logic        range_error;
      logic        saturated;
   } count_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [RSP_TUSER_BITS-1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Shadow copy of the counting state.
   bit [COUNT_BITS-1:0] emission_shadow [EMIT_DEPTH];
   bit [COUNT_BITS-1:0] transition_shadow [TRANS_DEPTH];
   bit [COUNT_BITS-1:0] category_shadow [MAX_STATES];
   bit [COUNT_BITS-1:0] first_shadow [MAX_STATES];
   bit [COUNT_BITS-1:0] sentences_shadow;
   bit [STATE_BITS-1:0] prior_label_shadow;
   bit sentence_open_shadow;
   bit [STATES_REG_BITS-1:0] states_reg = ACTIVE_STATES_RESET;
   bit [SYMBOLS_REG_BITS-1:0] symbols_reg = ACTIVE_SYMBOLS_RESET;

   count_request_type pending_reqs[$];
   count_result_type expected_counts[$];
   logic req_taken = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_trigger = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int stall_cycles = 0;
   int mismatch_count = 0;

   hmm_transition_emission_counter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit [COUNT_BITS-1:0] bump(inout bit [COUNT_BITS-1:0] counter,
                                                inout bit held);
      if (counter == '1) begin
         held = 1'b1;
      end else begin
         counter = counter + 1'b1;
      end
      return counter;
   endfunction

   function automatic count_result_type predict_counts(input count_request_type rq);
      count_result_type r;
      int state_lim;
      int symbol_lim;
      bit bad;
      bit held;
      int e_addr;
      int t_addr;
      state_lim = (int'(states_reg) < MAX_STATES) ? int'(states_reg) : MAX_STATES;
      symbol_lim = (int'(symbols_reg) < MAX_SYMBOLS) ? int'(symbols_reg) : MAX_SYMBOLS;
      r = '{default: '0};
      held = 1'b0;
      bad = (rq.label >= state_lim) || (rq.word >= symbol_lim);
      e_addr = rq.label * MAX_SYMBOLS + rq.word;
      if (rq.kind == KIND_READ) begin
         if (rq.from_label >= state_lim) begin
            bad = 1'b1;
         end
         if (!bad) begin
            r.emission = emission_shadow[e_addr];
            r.transition = transition_shadow[rq.from_label * MAX_STATES + rq.label];
            r.category = category_shadow[rq.label];
            r.first_label = first_shadow[rq.label];
            r.sentences = sentences_shadow;
         end
      end else begin
         // A word that continues a sentence needs an open sentence whose last
         // label is still inside the current state range.
         if (!rq.sentence_start && (!sentence_open_shadow || prior_label_shadow >= state_lim)) begin
            bad = 1'b1;
         end
         if (!bad) begin
            r.emission = bump(emission_shadow[e_addr], held);
            r.category = bump(category_shadow[rq.label], held);
            if (rq.sentence_start) begin
               r.first_label = bump(first_shadow[rq.label], held);
               r.sentences = bump(sentences_shadow, held);
               sentence_open_shadow = 1'b1;
            end else begin
               t_addr = prior_label_shadow * MAX_STATES + rq.label;
               r.transition = bump(transition_shadow[t_addr], held);
               r.first_label = first_shadow[rq.label];
               r.sentences = sentences_shadow;
            end
            prior_label_shadow = rq.label;
         end
      end
      r.range_error = bad;
      r.saturated = held;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Request driver.
   always @(negedge clock) begin
      count_request_type nxt;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {1'b0, nxt.sentence_start, nxt.from_label, nxt.label, nxt.word};
            req_tuser <= nxt.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver, with one long hold-off when requested.
   always @(negedge clock) begin
      if (hold_trigger && !hold_done) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: checks responses, predicts accepted requests, runs the watchdog.
   always @(posedge clock) begin
      count_result_type want;
      count_request_type rq;
      bit req_fire;
      bit rsp_fire;
      req_fire = !reset && req_tvalid && (req_tready === 1'b1);
      rsp_fire = !reset && (rsp_tvalid === 1'b1) && rsp_tready;
      req_taken <= req_fire;
      if (rsp_fire) begin
         if (expected_counts.size() == 0) begin
            $error("response arrived with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_counts.pop_front();
            check_field("emission_count", want.emission, rsp_tdata[31:0]);
            check_field("transition_count", want.transition, rsp_tdata[63:32]);
            check_field("category_count", want.category, rsp_tdata[95:64]);
            check_field("first_count", want.first_label, rsp_tdata[127:96]);
            check_field("sentence_count", want.sentences, rsp_tdata[159:128]);
            check_field("range_error", 32'(want.range_error), 32'(rsp_tuser[0]));
            check_field("saturated", 32'(want.saturated), 32'(rsp_tuser[1]));
         end
      end
      if (req_fire) begin
         rq.kind = req_tuser;
         rq.word = req_tdata[9:0];
         rq.label = req_tdata[15:10];
         rq.from_label = req_tdata[21:16];
         rq.sentence_start = req_tdata[22];
         expected_counts.push_back(predict_counts(rq));
      end
      if (req_fire || rsp_fire) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic push_req(input logic kind, input int word, input int label,
                           input int from_label, input int start);
      count_request_type rq;
      rq.kind = kind;
      rq.word = SYMBOL_BITS'(word);
      rq.label = STATE_BITS'(label);
      rq.from_label = STATE_BITS'(from_label);
      rq.sentence_start = (start != 0);
      pending_reqs.push_back(rq);
   endtask

   task automatic wait_drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_counts.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_ACTIVE_STATES) begin
         states_reg = value[STATES_REG_BITS-1:0];
      end else begin
         symbols_reg = value[SYMBOLS_REG_BITS-1:0];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly indices from a small set, so counters climb past one.
   function automatic int pick_index(input int lim, input int hot);
      int top;
      top = (lim < hot) ? lim : hot;
      if ($urandom_range(0, 2) == 0) begin
         return int'($urandom_range(0, lim - 1));
      end
      return int'($urandom_range(0, top - 1));
   endfunction

   function automatic count_request_type random_request(input int state_lim,
                                                        input int symbol_lim);
      count_request_type rq;
      int dice;
      dice = $urandom_range(0, 99);
      rq.from_label = STATE_BITS'($urandom_range(0, MAX_STATES - 1));
      rq.sentence_start = ($urandom_range(0, 4) == 0);
      if (dice < 8) begin
         rq.kind = 1'($urandom_range(0, 1));
         rq.word = SYMBOL_BITS'($urandom_range(0, MAX_SYMBOLS - 1));
         rq.label = STATE_BITS'($urandom_range(0, MAX_STATES - 1));
         rq.sentence_start = 1'($urandom_range(0, 1));
      end else begin
         rq.kind = (dice < 30) ? KIND_READ : KIND_COUNT;
         rq.word = SYMBOL_BITS'(pick_index(symbol_lim, 6));
         rq.label = STATE_BITS'(pick_index(state_lim, 4));
         if (rq.kind == KIND_READ && $urandom_range(0, 9) != 0) begin
            rq.from_label = STATE_BITS'(pick_index(state_lim, 4));
         end
      end
      return rq;
   endfunction

   initial begin
      int state_vals [RANDOM_PHASES] = '{64, 127, 8, 1, 64, 33, 2, 100, 16, 64};
      int symbol_vals [RANDOM_PHASES] = '{1024, 2047, 16, 1, 1024, 700, 3, 1500, 1024, 5};
      int state_lim;
      int symbol_lim;
      int mode;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset configuration. The first word arrives
      // before any sentence has begun and must be rejected.
      push_req(KIND_COUNT, 5, 7, 0, 0);
      push_req(KIND_READ, 1023, 63, 63, 0);
      push_req(KIND_COUNT, 0, 0, 0, 1);
      push_req(KIND_COUNT, 1023, 63, 63, 0);
      push_req(KIND_COUNT, 1023, 63, 0, 0);
      push_req(KIND_READ, 1023, 63, 63, 0);
      push_req(KIND_READ, 1023, 63, 0, 1);
      push_req(KIND_COUNT, 1023, 63, 0, 1);
      push_req(KIND_READ, 0, 0, 0, 0);
      wait_drain();

      // Registers above the table sizes clamp to the full range.
      write_csr(CSR_ACTIVE_STATES, 11'h7FF);
      write_csr(CSR_ACTIVE_SYMBOLS, 11'h7FF);
      push_req(KIND_COUNT, 512, 32, 21, 0);
      push_req(KIND_READ, 512, 32, 63, 0);
      wait_drain();

      // With no states in use every request is rejected.
      write_csr(CSR_ACTIVE_STATES, 11'd0);
      push_req(KIND_COUNT, 0, 0, 0, 1);
      push_req(KIND_READ, 0, 0, 0, 0);
      wait_drain();

      write_csr(CSR_ACTIVE_STATES, 11'd1);
      write_csr(CSR_ACTIVE_SYMBOLS, 11'd1);
      push_req(KIND_COUNT, 0, 0, 0, 1);
      push_req(KIND_COUNT, 1, 0, 0, 0);
      push_req(KIND_COUNT, 0, 1, 0, 1);
      push_req(KIND_READ, 0, 0, 1, 0);
      push_req(KIND_COUNT, 0, 0, 0, 0);
      wait_drain();

      write_csr(CSR_ACTIVE_SYMBOLS, 11'd0);
      push_req(KIND_READ, 0, 0, 0, 0);
      wait_drain();

      // Lowering the state count below the last label strands the sentence
      // until a new one starts.
      write_csr(CSR_ACTIVE_STATES, 11'd64);
      write_csr(CSR_ACTIVE_SYMBOLS, 11'd1024);
      push_req(KIND_COUNT, 9, 40, 0, 1);
      wait_drain();
      write_csr(CSR_ACTIVE_STATES, 11'd10);
      push_req(KIND_COUNT, 9, 3, 0, 0);
      push_req(KIND_COUNT, 9, 3, 0, 1);
      push_req(KIND_COUNT, 9, 3, 0, 0);
      wait_drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_csr(CSR_ACTIVE_STATES,
                   CSR_DATA_BITS'(state_vals[p] | ($urandom_range(0, 15) << 7)));
         write_csr(CSR_ACTIVE_SYMBOLS, CSR_DATA_BITS'(symbol_vals[p]));
         @(posedge clock);
         mode = p % 4;
         send_idle_pct = (mode == 1) ? 57 : (mode == 3) ? 21 : 0;
         recv_idle_pct = (mode == 2) ? 57 : (mode == 3) ? 21 : 0;
         if (p == 4) begin
            hold_trigger = 1'b1;
         end
         state_lim = (int'(states_reg) < MAX_STATES) ? int'(states_reg) : MAX_STATES;
         symbol_lim = (int'(symbols_reg) < MAX_SYMBOLS) ? int'(symbols_reg) : MAX_SYMBOLS;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            pending_reqs.push_back(random_request(state_lim, symbol_lim));
         end
         wait_drain();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
